>>> hw/rtl/indexed_list_engine_macros.svh
// Assertion macros for the indexed list engine.
// Needs only a clock and an active-high reset in the including scope.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication
`define ILE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("indexed_list_engine: same-cycle check failed");

// Next-cycle implication
`define ILE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("indexed_list_engine: next-cycle check failed");

`endif

>>> hw/rtl/ile_pkg.sv
// Shared types and codes for the indexed list engine.
// No dependencies.
`timescale 1ns / 1ps

package ile_pkg;

   localparam logic [2:0] OP_READ   = 3'd0;
   localparam logic [2:0] OP_HEAD   = 3'd1;
   localparam logic [2:0] OP_TAIL   = 3'd2;
   localparam logic [2:0] OP_BEFORE = 3'd3;
   localparam logic [2:0] OP_DELETE = 3'd4;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int unsigned POS_W = 8;
   localparam int unsigned CMP_W = POS_W + 1;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [POS_W-1:0]   position;
      logic signed [31:0] item_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [4:0]         item_count;
   } rsp_payload_type;

endpackage

>>> hw/rtl/ile_core.sv
// Element register array and count with the combinational read/insert/delete logic.
// Depends on ile_pkg.
`timescale 1ns / 1ps

module ile_core #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     exec,
   input  ile_pkg::req_payload_type cmd,
   output ile_pkg::rsp_payload_type result
);
   import ile_pkg::*;

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = $clog2(CAPACITY);

   logic signed [31:0] store_ff [CAPACITY];
   logic signed [31:0] store_in [CAPACITY];
   logic signed [31:0] shift_up [CAPACITY];
   logic signed [31:0] shift_dn [CAPACITY];
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;

   logic [CMP_W-1:0] pos_w;
   logic [CMP_W-1:0] cnt_w;
   logic [CMP_W-1:0] ins_pos;
   logic [CMP_W-1:0] cnt_after_w;
   logic             full;
   logic             ins_req;
   logic             do_ins;
   logic             do_del;
   logic signed [31:0] rd_value;
   logic [1:0]       status;

   assign pos_w = {1'b0, cmd.position};
   assign cnt_w = CMP_W'(count_ff);
   assign full  = (count_ff == CW'(CAPACITY));

   always_comb begin
      rd_value = '0;
      status   = ST_DONE;
      ins_req  = 1'b0;
      ins_pos  = '0;
      do_del   = 1'b0;
      unique case (cmd.opcode)
         OP_READ: begin
            if (pos_w < cnt_w) begin
               rd_value = store_ff[cmd.position[IW-1:0]];
            end else begin
               rd_value = -32'sd1;
               status   = ST_RANGE;
            end
         end
         OP_HEAD: begin
            ins_req = 1'b1;
         end
         OP_TAIL: begin
            ins_req = 1'b1;
            ins_pos = cnt_w;
         end
         OP_BEFORE: begin
            if (pos_w > cnt_w) begin
               status = ST_RANGE;
            end else begin
               ins_req = 1'b1;
               ins_pos = pos_w;
            end
         end
         OP_DELETE: begin
            if (pos_w >= cnt_w) begin
               status = ST_RANGE;
            end else begin
               do_del = 1'b1;
            end
         end
         default: begin
         end
      endcase
      do_ins = ins_req && !full;
      if (ins_req && full) begin
         status = ST_FULL;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CW'(1);
      end else if (do_del) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign cnt_after_w = CMP_W'(count_in);

   assign result.read_value = rd_value;
   assign result.status     = status;
   assign result.item_count = cnt_after_w[4:0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
      if (i == 0) begin : g_first
         assign shift_up[i] = store_ff[i];
      end else begin : g_rest
         assign shift_up[i] = store_ff[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign shift_dn[i] = store_ff[i];
      end else begin : g_inner
         assign shift_dn[i] = store_ff[i+1];
      end

      always_comb begin
         store_in[i] = store_ff[i];
         if (do_ins && (CMP_W'(i) == ins_pos)) begin
            store_in[i] = cmd.item_value;
         end else if (do_ins && (CMP_W'(i) > ins_pos)) begin
            store_in[i] = shift_up[i];
         end else if (do_del && (CMP_W'(i) >= pos_w)) begin
            store_in[i] = shift_dn[i];
         end
      end

      always_ff @(posedge clock) begin
         if (exec) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (exec) begin
         count_ff <= count_in;
      end
   end

endmodule

>>> hw/rtl/indexed_list_engine.sv
// Indexed list engine: a request beat is taken into the input register, then passes once through
// the element array into the result register, from which the response beat is offered.
// Throughput one beat per cycle while rsp_ready is high; a response held by rsp_ready
// low stalls the request side once the input register is also occupied.
// Reset clears the element count and both stage valids; element contents are
// left as they are and are never read before being written.
`timescale 1ns / 1ps
`include "indexed_list_engine_macros.svh"

module indexed_list_engine #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ile_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ile_pkg::rsp_payload_type rsp_payload
);
   import ile_pkg::*;

   logic            in_valid_ff;
   req_payload_type in_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   rsp_payload_type result;
   logic            exec;

   assign exec      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || exec;

   ile_core #(
      .CAPACITY(CAPACITY)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .exec  (exec),
      .cmd   (in_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ILE_ASSERT_NEXT(a_exec_gives_rsp, clock, reset, exec, rsp_valid_ff)
   `ILE_ASSERT_NEXT(a_stalled_cmd_holds, clock, reset, in_valid_ff && !exec,
                    in_valid_ff && $stable(in_ff))
   `ILE_ASSERT_NOW(a_full_count, clock, reset, rsp_valid_ff && (rsp_ff.status == ST_FULL),
                   rsp_ff.item_count == 5'(CAPACITY))

endmodule

>>> verif/indexed_list_engine_checker.sv
// Checker for the indexed list engine: watches both channels, keeps its own copy
// of the list, predicts each response beat and compares it field by field.
// Depends on ile_pkg for the payload types and the opcode and status codes.
`timescale 1ns / 1ps

module indexed_list_engine_checker #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  ile_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  ile_pkg::rsp_payload_type rsp_payload,
   output int unsigned              mismatch_count,
   output int unsigned              outcomes_pending
);
   import ile_pkg::*;

   logic signed [31:0] list_copy [CAPACITY];
   int unsigned        list_length = 0;
   rsp_payload_type    outcome_queue [$];
   rsp_payload_type    want;
   int unsigned        fault_tally = 0;
   int unsigned        queue_depth = 0;

   assign mismatch_count   = fault_tally;
   assign outcomes_pending = queue_depth;

   function automatic rsp_payload_type apply_list_command(input req_payload_type cmd);
      rsp_payload_type outcome;
      int unsigned     slot;
      int              i;
      outcome = '0;
      outcome.status = ST_DONE;
      case (cmd.opcode)
         OP_READ: begin
            if (cmd.position < list_length) begin
               outcome.read_value = list_copy[cmd.position];
            end else begin
               outcome.read_value = -32'sd1;
               outcome.status = ST_RANGE;
            end
         end
         OP_HEAD, OP_TAIL, OP_BEFORE: begin
            if (cmd.opcode == OP_HEAD) begin
               slot = 0;
            end else if (cmd.opcode == OP_TAIL) begin
               slot = list_length;
            end else begin
               slot = cmd.position;
            end
            // range is reported ahead of a full list
            if (slot > list_length) begin
               outcome.status = ST_RANGE;
            end else if (list_length >= CAPACITY) begin
               outcome.status = ST_FULL;
            end else begin
               for (i = list_length; i > slot; i--) list_copy[i] = list_copy[i - 1];
               list_copy[slot] = cmd.item_value;
               list_length++;
            end
         end
         OP_DELETE: begin
            if (cmd.position >= list_length) begin
               outcome.status = ST_RANGE;
            end else begin
               for (i = cmd.position; i + 1 < list_length; i++) list_copy[i] = list_copy[i + 1];
               list_length--;
            end
         end
         default: ;
      endcase
      outcome.item_count = 5'(list_length);
      return outcome;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         list_length = 0;
         outcome_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_queue.size() == 0) begin
               $error("response beat with nothing outstanding: %p", rsp_payload);
               fault_tally++;
            end else begin
               want = outcome_queue.pop_front();
               if (rsp_payload.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d",
                         want.read_value, rsp_payload.read_value);
                  fault_tally++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
                  fault_tally++;
               end
               if (rsp_payload.item_count !== want.item_count) begin
                  $error("item_count: expected %0d, got %0d",
                         want.item_count, rsp_payload.item_count);
                  fault_tally++;
               end
            end
         end
         if (req_valid && req_ready) outcome_queue.push_back(apply_list_command(req_payload));
      end
      queue_depth = outcome_queue.size();
   end

endmodule

>>> verif/tb_indexed_list_engine.sv
// Top of the indexed list engine testbench: clock, reset, command stimulus,
// response back-pressure and the verdict. Depends on ile_pkg, indexed_list_engine
// and indexed_list_engine_checker.
`timescale 1ns / 1ps

module tb_indexed_list_engine;
   import ile_pkg::*;

   localparam int unsigned CAPACITY        = 16;
   localparam int unsigned RANDOM_ITEMS    = 850;
   localparam int unsigned IDLE_PERCENT    = 27;
   localparam int unsigned HOLD_OFF_CYCLES = 80;
   localparam int unsigned CYCLE_LIMIT     = 200000;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;
   int unsigned     mismatch_count;
   int unsigned     outcomes_pending;
   int unsigned     beats_sent  = 0;
   int unsigned     cycle_count = 0;
   bit              calm_window = 1'b0;

   indexed_list_engine #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   indexed_list_engine_checker #(
      .CAPACITY(CAPACITY)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .mismatch_count  (mismatch_count),
      .outcomes_pending(outcomes_pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return 32'sd0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_command(input logic [2:0] op, input logic [POS_W-1:0] pos,
                               input logic signed [31:0] val);
      while (!calm_window && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{opcode: op, position: pos, item_value: val};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   initial begin
      int unsigned      k;
      int unsigned      roll;
      bit               filling;
      logic [2:0]       op;
      logic [POS_W-1:0] pos;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty list
      send_command(OP_READ, '0, 32'sd0);
      send_command(OP_DELETE, '0, 32'sd0);
      send_command(OP_BEFORE, POS_W'(1), 32'sd0);
      // fill to capacity with every insert form
      for (k = 0; k < CAPACITY; k++) begin
         case (k % 3)
            0:       op = OP_TAIL;
            1:       op = OP_HEAD;
            default: op = OP_BEFORE;
         endcase
         pos = (k == 2) ? POS_W'(k) : POS_W'(k / 2);
         send_command(op, pos, (k == 0) ? 32'sh7fff_ffff :
                               (k == 1) ? 32'sh8000_0000 : pick_value());
      end
      // full list
      send_command(OP_HEAD, '0, -32'sd1);
      send_command(OP_TAIL, '0, 32'sd5);
      send_command(OP_BEFORE, POS_W'(CAPACITY + 1), 32'sd7);
      send_command(OP_READ, POS_W'(CAPACITY), 32'sd0);
      send_command(OP_READ, '1, 32'sd0);
      send_command(OP_DELETE, '1, 32'sd0);
      send_command(OP_DELETE, POS_W'(CAPACITY - 1), 32'sd0);
      send_command(OP_DELETE, '0, 32'sd0);
      // spare opcodes
      op = OP_DELETE;
      do begin
         op++;
         send_command(op, POS_W'($urandom_range(0, 255)), $urandom);
      end while (op != '1);

      for (k = 0; k < RANDOM_ITEMS; k++) begin
         filling     = ((k / 60) % 2) == 0;
         calm_window = (k >= 450 && k < 600);
         roll = $urandom_range(0, 99);
         if (roll >= 94) begin
            op = 3'($urandom_range(0, 7));
         end else if (filling) begin
            op = (roll < 15) ? OP_READ : (roll < 35) ? OP_HEAD : (roll < 55) ? OP_TAIL :
                 (roll < 78) ? OP_BEFORE : OP_DELETE;
         end else begin
            op = (roll < 20) ? OP_READ : (roll < 28) ? OP_HEAD : (roll < 36) ? OP_TAIL :
                 (roll < 44) ? OP_BEFORE : OP_DELETE;
         end
         if ($urandom_range(0, 9) == 0) begin
            pos = POS_W'($urandom_range(0, 255));
         end else begin
            pos = POS_W'($urandom_range(0, CAPACITY + 1));
         end
         send_command(op, pos, pick_value());
      end
      calm_window = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      while (outcomes_pending != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[indexed_list_engine] OK");
      end else begin
         $display("[indexed_list_engine] ERROR");
      end
      $finish;
   end

   initial begin
      bit held_off;
      held_off = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_off && beats_sent >= 250) begin
            // hold off long enough for the pipeline to back up into the request side
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (calm_window) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[indexed_list_engine] ERROR");
      $finish;
   end

endmodule
